@@ hw/rtl/box_mean_filter_2d_core_macros.svh @@
// Assertion macros shared by the box mean filter RTL.
// No dependencies; included by modules that carry assertions.
`ifndef BOX_MEAN_FILTER_2D_CORE_MACROS_SVH
`define BOX_MEAN_FILTER_2D_CORE_MACROS_SVH

// property must hold at every clock outside reset
`define BMF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be true outside reset
`define BMF_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ hw/rtl/bmf_pkg.sv @@
// Package for the box mean filter: field widths, register codes, defaults, cfg struct.
// No dependencies.
package bmf_pkg;
   localparam int PIXEL_FIELD_BITS = 16;
   localparam int MEAN_BITS        = 24;
   localparam int FRAC_BITS        = 8;
   localparam int ROW_BITS         = 12;
   localparam int MAX_HEIGHT       = 4096;
   localparam int DIM_BITS         = 13;
   localparam int CFG_WIDTH_BITS   = 11;
   localparam int CFG_HEIGHT_BITS  = 13;
   localparam int CFG_RADIUS_BITS  = 2;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 13;
   localparam int EFF_RADIUS_BITS  = 3;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_RADIUS = 3;
   localparam int DEF_PIXEL_BITS = 16;

   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RADIUS       = 2'd2;

   localparam logic [CFG_WIDTH_BITS-1:0]  RST_IMAGE_WIDTH  = 11'd1024;
   localparam logic [CFG_HEIGHT_BITS-1:0] RST_IMAGE_HEIGHT = 13'd1024;
   localparam logic [CFG_RADIUS_BITS-1:0] RST_RADIUS       = 2'd1;

   // effective (clamped) geometry handed from front to back
   typedef struct packed {
      logic [DIM_BITS-1:0]        width;
      logic [DIM_BITS-1:0]        height;
      logic [EFF_RADIUS_BITS-1:0] radius;
   } cfg_type;
endpackage

@@ hw/rtl/bmf_queue.sv @@
// Two-entry job queue between the front and back of the box mean filter.
// Depends on box_mean_filter_2d_core_macros.svh.
`include "box_mean_filter_2d_core_macros.svh"
module bmf_queue #(
   parameter int DATA_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output logic [DATA_BITS-1:0] pop_data
);
   logic [DATA_BITS-1:0] slots_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = slots_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      else if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ptr_ff] <= push_data;
   end

   `BMF_NEVER(a_no_overflow, clock, reset, push && full && !pop, "queue overflow")
   `BMF_NEVER(a_no_underflow, clock, reset, pop && !not_empty, "queue underflow")
   `BMF_ASSERT(a_ptr_count, clock, reset, (count_ff == 2'd1) == (wr_ptr_ff != rd_ptr_ff), "pointers disagree with count")
endmodule

@@ hw/rtl/bmf_front.sv @@
// Front of the box mean filter: config registers, stream counters, job classification.
// Depends on bmf_pkg.
module bmf_front #(
   parameter int MAX_WIDTH  = bmf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_RADIUS = bmf_pkg::DEF_MAX_RADIUS,
   parameter int PIXEL_BITS = bmf_pkg::DEF_PIXEL_BITS,
   parameter int COLW       = $clog2(MAX_WIDTH),
   parameter int RING       = 2 * MAX_RADIUS + 2,
   parameter int RINGW      = $clog2(RING),
   parameter int JOBW       = 3 + RINGW + COLW + PIXEL_BITS + bmf_pkg::ROW_BITS + COLW + RINGW
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bmf_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [bmf_pkg::CSR_DATA_BITS-1:0]     csr_data,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [bmf_pkg::PIXEL_FIELD_BITS-1:0]  req_tdata,
   input  logic                                  req_tuser,
   output bmf_pkg::cfg_type                      cfg,
   output logic                                  job_push,
   output logic [JOBW-1:0]                       job_data,
   input  logic                                  job_full
);
   localparam int DW = bmf_pkg::DIM_BITS;
   localparam int RB = bmf_pkg::ROW_BITS;

   logic [bmf_pkg::CFG_WIDTH_BITS-1:0]  width_ff;
   logic [bmf_pkg::CFG_HEIGHT_BITS-1:0] height_ff;
   logic [bmf_pkg::CFG_RADIUS_BITS-1:0] radius_ff;
   logic [COLW-1:0]  in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [RB-1:0]    in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [RINGW-1:0] in_ring_ff, in_ring_in, out_ring_ff, out_ring_in;
   logic             in_done_ff, in_done_in;

   logic [DW-1:0] ew, eh, nr, nc;
   logic          accept, wr, ready, last, csr_hit;

   assign csr_ready  = 1'b1;
   assign req_tready = !job_full;
   assign accept     = req_tvalid && !job_full;
   assign csr_hit    = csr_valid && (csr_index == bmf_pkg::REG_IMAGE_WIDTH
                       || csr_index == bmf_pkg::REG_IMAGE_HEIGHT
                       || csr_index == bmf_pkg::REG_RADIUS);

   always_comb begin
      ew = DW'(width_ff);
      if (ew == '0) ew = DW'(1);
      if (ew > DW'(MAX_WIDTH)) ew = DW'(MAX_WIDTH);
      eh = height_ff;
      if (eh == '0) eh = DW'(1);
      if (eh > DW'(bmf_pkg::MAX_HEIGHT)) eh = DW'(bmf_pkg::MAX_HEIGHT);
      cfg.width  = ew;
      cfg.height = eh;
      cfg.radius = (3'(radius_ff) > 3'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : 3'(radius_ff);
   end

   always_comb begin
      wr         = accept && !req_tuser && !in_done_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      in_ring_in = in_ring_ff;
      in_done_in = in_done_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_ring_in = out_ring_ff;
      if (wr) begin
         if (DW'(in_col_ff) + DW'(1) >= ew) begin
            in_col_in = '0;
            if (DW'(in_row_ff) + DW'(1) >= eh) begin
               in_row_in  = '0;
               in_ring_in = '0;
               in_done_in = 1'b1;
            end else begin
               in_row_in  = in_row_ff + RB'(1);
               in_ring_in = (in_ring_ff == RINGW'(RING - 1)) ? '0 : in_ring_ff + RINGW'(1);
            end
         end else begin
            in_col_in = in_col_ff + COLW'(1);
         end
      end
      nr = DW'(out_row_ff) + DW'(cfg.radius);
      if (nr > eh - DW'(1)) nr = eh - DW'(1);
      nc = DW'(out_col_ff) + DW'(cfg.radius);
      if (nc > ew - DW'(1)) nc = ew - DW'(1);
      ready = accept && (in_done_in || DW'(in_row_in) > nr
              || (DW'(in_row_in) == nr && DW'(in_col_in) > nc));
      last  = (DW'(out_row_ff) == eh - DW'(1)) && (DW'(out_col_ff) == ew - DW'(1));
      if (ready) begin
         if (DW'(out_col_ff) + DW'(1) >= ew) begin
            out_col_in  = '0;
            out_row_in  = out_row_ff + RB'(1);
            out_ring_in = (out_ring_ff == RINGW'(RING - 1)) ? '0 : out_ring_ff + RINGW'(1);
         end else begin
            out_col_in = out_col_ff + COLW'(1);
         end
         if (last) begin
            in_col_in = '0; in_row_in = '0; in_ring_in = '0; in_done_in = 1'b0;
            out_col_in = '0; out_row_in = '0; out_ring_in = '0;
         end
      end
   end

   assign job_push = wr || ready;
   // job layout, low to high: ring, col, pixel, wr, emit, last, out ring, out col, out row
   assign job_data = {out_row_ff, out_col_ff, out_ring_ff, ready && last, ready, wr,
                      req_tdata[PIXEL_BITS-1:0], in_col_ff, in_ring_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bmf_pkg::RST_IMAGE_WIDTH;
         height_ff <= bmf_pkg::RST_IMAGE_HEIGHT;
         radius_ff <= bmf_pkg::RST_RADIUS;
         in_col_ff <= '0; in_row_ff <= '0; in_ring_ff <= '0; in_done_ff <= 1'b0;
         out_col_ff <= '0; out_row_ff <= '0; out_ring_ff <= '0;
      end else if (csr_hit) begin
         case (csr_index)
            bmf_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_data[bmf_pkg::CFG_WIDTH_BITS-1:0];
            bmf_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_data;
            bmf_pkg::REG_RADIUS:       radius_ff <= csr_data[bmf_pkg::CFG_RADIUS_BITS-1:0];
            default: ;
         endcase
         in_col_ff <= '0; in_row_ff <= '0; in_ring_ff <= '0; in_done_ff <= 1'b0;
         out_col_ff <= '0; out_row_ff <= '0; out_ring_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         in_ring_ff <= in_ring_in;
         in_done_ff <= in_done_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         out_ring_ff <= out_ring_in;
      end
   end
endmodule

@@ hw/rtl/bmf_back.sv @@
// Back of the box mean filter: row store memory, window sum, serial divide, result register.
// Depends on bmf_pkg.
module bmf_back #(
   parameter int MAX_WIDTH  = bmf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_RADIUS = bmf_pkg::DEF_MAX_RADIUS,
   parameter int PIXEL_BITS = bmf_pkg::DEF_PIXEL_BITS,
   parameter int COLW       = $clog2(MAX_WIDTH),
   parameter int RING       = 2 * MAX_RADIUS + 2,
   parameter int RINGW      = $clog2(RING),
   parameter int JOBW       = 3 + RINGW + COLW + PIXEL_BITS + bmf_pkg::ROW_BITS + COLW + RINGW
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bmf_pkg::cfg_type               cfg,
   input  logic                           job_valid,
   input  logic [JOBW-1:0]                job_data,
   output logic                           job_pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [bmf_pkg::MEAN_BITS-1:0]  rsp_tdata,
   output logic                           rsp_tlast
);
   localparam int RB      = bmf_pkg::ROW_BITS;
   localparam int DEPTH   = RING * MAX_WIDTH;
   localparam int ADDRW   = $clog2(DEPTH);
   localparam int SIDEW   = $clog2(2 * MAX_RADIUS + 2);
   localparam int AREA_MX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
   localparam int AREAW   = $clog2(AREA_MX + 1);
   localparam int SUMW    = PIXEL_BITS + AREAW;
   localparam int DVW     = SUMW + bmf_pkg::FRAC_BITS;
   localparam int CNTW    = $clog2(DVW);
   localparam int MB      = bmf_pkg::MEAN_BITS;
   localparam int SW      = 15;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SUM   = 3'd1;
   localparam logic [2:0] ST_FLUSH = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [PIXEL_BITS-1:0] mem [DEPTH];
   logic [PIXEL_BITS-1:0] rdata_ff;

   // job unpack
   logic [RINGW-1:0]      j_ring, j_oring;
   logic [COLW-1:0]       j_col, j_ocol;
   logic [PIXEL_BITS-1:0] j_pix;
   logic                  j_wr, j_emit, j_last;
   logic [RB-1:0]         j_orow;
   assign {j_orow, j_ocol, j_oring, j_last, j_emit, j_wr, j_pix, j_col, j_ring} = job_data;

   logic [2:0]       state_ff, state_in;
   logic [RB-1:0]    orow_ff, orow_in;
   logic [COLW-1:0]  ocol_ff, ocol_in;
   logic [RINGW-1:0] oring_ff, oring_in;
   logic             last_ff, last_in;
   logic [SIDEW-1:0] dy_ff, dy_in, dx_ff, dx_in, side;
   logic             rd_pend_ff, rd_pend_in;
   logic [SUMW-1:0]  acc_ff, acc_in;
   logic [DVW-1:0]   dvd_ff, dvd_in;
   logic [AREAW-1:0] rem_ff, rem_in, area;
   logic [AREAW:0]   rem_sh;
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic             out_valid_ff, out_valid_in, out_last_ff, out_last_in;
   logic [MB-1:0]    out_data_ff, out_data_in;
   logic [MB+DVW-1:0] q_ext;

   logic signed [SW-1:0] t_row, t_col, delta, ring_s;
   logic [RB-1:0]        row_c;
   logic [COLW-1:0]      col_c;
   logic [ADDRW-1:0]     raddr, waddr;
   logic                 rd_en, wr_en;

   assign side = SIDEW'({cfg.radius, 1'b1});
   assign area = AREAW'(side) * AREAW'(side);

   // clamped window address for the current tap
   always_comb begin
      t_row = $signed(SW'(orow_ff)) + $signed(SW'(dy_ff)) - $signed(SW'(cfg.radius));
      if (t_row < 0) t_row = '0;
      else if (t_row > $signed(SW'(cfg.height) - SW'(1))) t_row = $signed(SW'(cfg.height) - SW'(1));
      row_c  = t_row[RB-1:0];
      delta  = $signed(SW'(row_c)) - $signed(SW'(orow_ff));
      ring_s = $signed(SW'(oring_ff)) + delta;
      if (ring_s < 0) ring_s = ring_s + $signed(SW'(RING));
      else if (ring_s >= $signed(SW'(RING))) ring_s = ring_s - $signed(SW'(RING));
      t_col = $signed(SW'(ocol_ff)) + $signed(SW'(dx_ff)) - $signed(SW'(cfg.radius));
      if (t_col < 0) t_col = '0;
      else if (t_col > $signed(SW'(cfg.width) - SW'(1))) t_col = $signed(SW'(cfg.width) - SW'(1));
      col_c = t_col[COLW-1:0];
      raddr = ADDRW'(ring_s[RINGW-1:0]) * ADDRW'(MAX_WIDTH) + ADDRW'(col_c);
      waddr = ADDRW'(j_ring) * ADDRW'(MAX_WIDTH) + ADDRW'(j_col);
   end

   always_comb begin
      state_in = state_ff;
      orow_in = orow_ff; ocol_in = ocol_ff; oring_in = oring_ff; last_in = last_ff;
      dy_in = dy_ff; dx_in = dx_ff;
      rd_pend_in = 1'b0;
      acc_in = rd_pend_ff ? acc_ff + SUMW'(rdata_ff) : acc_ff;
      dvd_in = dvd_ff; rem_in = rem_ff; cnt_in = cnt_ff;
      rem_sh = {rem_ff, dvd_ff[DVW-1]};
      out_valid_in = out_valid_ff && !rsp_tready;
      out_last_in  = out_last_ff;
      out_data_in  = out_data_ff;
      q_ext = {MB'(0), dvd_ff};
      job_pop = 1'b0; wr_en = 1'b0; rd_en = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               wr_en   = j_wr;
               if (j_emit) begin
                  orow_in = j_orow; ocol_in = j_ocol; oring_in = j_oring; last_in = j_last;
                  dy_in = '0; dx_in = '0; acc_in = '0;
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            rd_en = 1'b1;
            rd_pend_in = 1'b1;
            if (dx_ff == side - SIDEW'(1)) begin
               dx_in = '0;
               if (dy_ff == side - SIDEW'(1)) state_in = ST_FLUSH;
               else dy_in = dy_ff + SIDEW'(1);
            end else begin
               dx_in = dx_ff + SIDEW'(1);
            end
         end
         ST_FLUSH: begin
            dvd_in = {acc_in, bmf_pkg::FRAC_BITS'(0)};
            rem_in = '0;
            cnt_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (rem_sh >= {1'b0, area}) begin
               rem_in = AREAW'(rem_sh - {1'b0, area});
               dvd_in = {dvd_ff[DVW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[AREAW-1:0];
               dvd_in = {dvd_ff[DVW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(DVW - 1)) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_last_in  = last_ff;
               out_data_in  = q_ext[MB-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[waddr] <= j_pix;
      if (rd_en) rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      orow_ff <= orow_in; ocol_ff <= ocol_in; oring_ff <= oring_in; last_ff <= last_in;
      dy_ff <= dy_in; dx_ff <= dx_in; acc_ff <= acc_in;
      dvd_ff <= dvd_in; rem_ff <= rem_in; cnt_ff <= cnt_in;
      out_last_ff <= out_last_in; out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
endmodule

@@ hw/rtl/box_mean_filter_2d_core.sv @@
// Top level of the streaming 2D box mean filter.
// Depends on bmf_pkg, bmf_front, bmf_queue, bmf_back.
//
//  channel | dir | handshake              | word contents (low bit first)
//  req     | in  | req_tvalid/req_tready  | tdata: pixel[15:0]; tuser: mode (1 = drain)
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata: mean_value[23:0]; tlast: frame_last
//  csr     | in  | csr_valid/csr_ready    | csr_index: register, csr_data: value
//
// The front takes one word per cycle while the two-entry job queue has room.
// A word that yields no result costs the back only a row store write.
// A word that yields a result costs the back one row store read per window tap,
// then a one-bit-per-cycle divide of the DVW-bit dividend by the window area, DVW
// being PIXEL_BITS + clog2((2*MAX_RADIUS+1)^2+1) + 8. That loop sets the rate.
// Synchronous active-high reset clears counters, sets config defaults; row store is not
// cleared (entries are always written before they are read). csr_ready stays high.
module box_mean_filter_2d_core #(
   parameter int MAX_WIDTH  = bmf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_RADIUS = bmf_pkg::DEF_MAX_RADIUS,
   parameter int PIXEL_BITS = bmf_pkg::DEF_PIXEL_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bmf_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [bmf_pkg::CSR_DATA_BITS-1:0]     csr_data,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [bmf_pkg::PIXEL_FIELD_BITS-1:0]  req_tdata,   // pixel
   input  logic                                  req_tuser,   // mode
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [bmf_pkg::MEAN_BITS-1:0]         rsp_tdata,   // mean_value
   output logic                                  rsp_tlast
);
   localparam int COLW  = $clog2(MAX_WIDTH);
   localparam int RING  = 2 * MAX_RADIUS + 2;
   localparam int RINGW = $clog2(RING);
   localparam int JOBW  = 3 + RINGW + COLW + PIXEL_BITS + bmf_pkg::ROW_BITS + COLW + RINGW;

   bmf_pkg::cfg_type cfg;
   logic             job_push, job_full, job_pop, job_valid;
   logic [JOBW-1:0]  job_in, job_out;

   bmf_front #(
      .MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS), .PIXEL_BITS(PIXEL_BITS),
      .COLW(COLW), .RING(RING), .RINGW(RINGW), .JOBW(JOBW)
   ) u_front (
      .clock, .reset,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .cfg,
      .job_push, .job_data(job_in), .job_full
   );

   bmf_queue #(.DATA_BITS(JOBW)) u_queue (
      .clock, .reset,
      .push(job_push), .push_data(job_in), .full(job_full),
      .pop(job_pop), .not_empty(job_valid), .pop_data(job_out)
   );

   bmf_back #(
      .MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS), .PIXEL_BITS(PIXEL_BITS),
      .COLW(COLW), .RING(RING), .RINGW(RINGW), .JOBW(JOBW)
   ) u_back (
      .clock, .reset,
      .cfg,
      .job_valid, .job_data(job_out), .job_pop,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
   );
endmodule

@@ bench/box_mean_filter_2d_core_tb.sv @@
// Self-checking testbench for box_mean_filter_2d_core: 2D box mean over a raster pixel stream.
// Depends on bmf_pkg and the filter RTL; holds its own predictor of the window mean.
module box_mean_filter_2d_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_ROWS   = 2 * bmf_pkg::DEF_MAX_RADIUS + 2;
   localparam int SETTLE      = 400;      // > two queued jobs at the widest window
   localparam int CYCLE_LIMIT = 4000000;

   typedef struct {
      logic [bmf_pkg::MEAN_BITS-1:0] mean_value;
      logic                          frame_last;
   } mean_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [bmf_pkg::CSR_INDEX_BITS-1:0] csr_index = bmf_pkg::REG_IMAGE_WIDTH;
   logic [bmf_pkg::CSR_DATA_BITS-1:0]  csr_data = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [bmf_pkg::PIXEL_FIELD_BITS-1:0] req_tdata = '0;   // pixel
   logic req_tuser = 1'b0;                                 // mode (1 = drain)
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [bmf_pkg::MEAN_BITS-1:0] rsp_tdata;               // mean_value
   logic rsp_tlast;                                        // frame_last

   box_mean_filter_2d_core i_dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always #2 clock = ~clock;

   // --- predictor state: mirror of the block's registers, counters and row ring ---
   logic [15:0] row_ring [RING_ROWS * bmf_pkg::DEF_MAX_WIDTH];
   logic [bmf_pkg::CFG_WIDTH_BITS-1:0]  width_reg  = bmf_pkg::RST_IMAGE_WIDTH;
   logic [bmf_pkg::CFG_HEIGHT_BITS-1:0] height_reg = bmf_pkg::RST_IMAGE_HEIGHT;
   logic [bmf_pkg::CFG_RADIUS_BITS-1:0] radius_reg = bmf_pkg::RST_RADIUS;
   int  in_col, in_row, out_col, out_row;
   bit  frame_in_full;     // last pixel of the frame taken, results still owed
   int  frames_done;
   int  words_sent;
   mean_word_type mean_q[$];

   int  errors = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;

   function automatic int eff_width();
      if (width_reg == 0) return 1;
      return (width_reg > bmf_pkg::DEF_MAX_WIDTH) ? bmf_pkg::DEF_MAX_WIDTH : int'(width_reg);
   endfunction

   function automatic int eff_height();
      if (height_reg == 0) return 1;
      return (height_reg > bmf_pkg::MAX_HEIGHT) ? bmf_pkg::MAX_HEIGHT : int'(height_reg);
   endfunction

   function automatic void restart_stream();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      frame_in_full = 0;
   endfunction

   // one accepted word: store the pixel, then emit the next mean if its window is complete
   function automatic void predict_window_mean(logic mode, logic [15:0] pix);
      int w, h, r, nr, nc, yy, xx, side;
      longint unsigned total;
      mean_word_type m;
      w = eff_width(); h = eff_height(); r = int'(radius_reg);
      if (!mode && !frame_in_full) begin
         row_ring[(in_row % RING_ROWS) * bmf_pkg::DEF_MAX_WIDTH + in_col] = pix;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= h) begin
               in_row = 0;
               frame_in_full = 1;
            end
         end
      end
      if (!frame_in_full) begin
         nr = (out_row + r > h - 1) ? h - 1 : out_row + r;
         nc = (out_col + r > w - 1) ? w - 1 : out_col + r;
         if (!(in_row > nr || (in_row == nr && in_col > nc))) return;
      end
      side = 2 * r + 1;
      total = 0;
      for (int dy = 0; dy < side; dy++) begin
         yy = out_row + dy - r;
         if (yy < 0) yy = 0;
         if (yy > h - 1) yy = h - 1;
         for (int dx = 0; dx < side; dx++) begin
            xx = out_col + dx - r;
            if (xx < 0) xx = 0;
            if (xx > w - 1) xx = w - 1;
            total += row_ring[(yy % RING_ROWS) * bmf_pkg::DEF_MAX_WIDTH + xx];
         end
      end
      m.mean_value = bmf_pkg::MEAN_BITS'((total << 8) / (side * side));
      m.frame_last = (out_row == h - 1) && (out_col == w - 1);
      mean_q.push_back(m);
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
      end
      if (m.frame_last) begin
         restart_stream();
         frames_done++;
      end
   endfunction

   // --- stimulus primitives ---
   task automatic send_word(input logic mode, input logic [15:0] pix);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
      predict_window_mean(mode, pix);
      words_sent++;
   endtask

   // wait for every owed mean, then let jobs that yield nothing finish too
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (mean_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [bmf_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [bmf_pkg::CSR_DATA_BITS-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         bmf_pkg::REG_IMAGE_WIDTH:  width_reg  = value[bmf_pkg::CFG_WIDTH_BITS-1:0];
         bmf_pkg::REG_IMAGE_HEIGHT: height_reg = value[bmf_pkg::CFG_HEIGHT_BITS-1:0];
         bmf_pkg::REG_RADIUS:       radius_reg = value[bmf_pkg::CFG_RADIUS_BITS-1:0];
         default: ;
      endcase
      restart_stream();
      @(posedge clock);
   endtask

   task automatic set_geometry(input int w, input int h, input int r);
      write_reg(bmf_pkg::REG_IMAGE_WIDTH, bmf_pkg::CSR_DATA_BITS'(w));
      write_reg(bmf_pkg::REG_IMAGE_HEIGHT, bmf_pkg::CSR_DATA_BITS'(h));
      write_reg(bmf_pkg::REG_RADIUS, bmf_pkg::CSR_DATA_BITS'(r));
   endtask

   function automatic logic [15:0] rand_pixel();
      case ($urandom_range(5))
         0: return 16'hFFFF;
         1: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // one frame with random content; drains sprinkled in, dropped pixels after the end
   task automatic stream_frame();
      int target;
      target = frames_done + 1;
      while (frames_done < target)
         send_word($urandom_range(99) < (frame_in_full ? 70 : 5), rand_pixel());
   endtask

   // --- tests ---
   task automatic test_tiny_frames();
      set_geometry(1, 1, 0);
      send_word(1'b1, 16'h0000);            // drain with nothing ready
      send_word(1'b0, 16'hFFFF);            // full-scale single pixel
      send_word(1'b0, 16'h0000);
      write_reg(bmf_pkg::REG_RADIUS, bmf_pkg::CSR_DATA_BITS'(3));   // widest window, one pixel
      send_word(1'b0, 16'hFFFF);
      send_word(1'b0, 16'h5A5A);
      set_geometry(0, 0, 1);                // zero size reads as one
      send_word(1'b0, 16'hA5A5);
      set_geometry(3, 2, 1);
      send_word(1'b0, 16'h0001);
      send_word(1'b1, 16'h0000);            // drain mid-frame, window not complete
      repeat (5) send_word(1'b0, 16'hFFFF);
      send_word(1'b0, 16'h1234);            // pixel past frame end is dropped
      while (frame_in_full) send_word(1'b1, 16'h0000);
      send_word(1'b0, 16'h8000);            // next frame, then abandon it
      write_reg(bmf_pkg::REG_RADIUS, bmf_pkg::CSR_DATA_BITS'(2));
   endtask

   task automatic test_edge_geometry();
      set_geometry(2047, 1, 3);             // width saturates at the row store size
      stream_frame();
      set_geometry(16, 8191, 0);            // height saturates; partial frame abandoned
      repeat (60) send_word(1'b0, rand_pixel());
      set_geometry(1, 8191, 3);
      repeat (20) send_word(1'b0, rand_pixel());
   endtask

   task automatic test_pause_until_drained();
      set_geometry(5, 4, 1);
      repeat (9) send_word(1'b0, rand_pixel());
      req_tvalid <= 1'b0;
      while (mean_q.size() != 0) @(posedge clock);
      stream_frame();
   endtask

   task automatic test_random_stream();
      int phase_end;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 53 : 0;
         recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 12 : 0;
         phase_end = words_sent + 150;
         while (words_sent < phase_end) begin
            set_geometry($urandom_range(12), $urandom_range(8), $urandom_range(3));
            if ($urandom_range(9) == 0) begin
               // broken frame: cut off by the next register write
               repeat ($urandom_range(1, 20)) send_word($urandom_range(9) == 0, rand_pixel());
            end else begin
               repeat ($urandom_range(1, 3)) stream_frame();
            end
         end
      end
      send_idle_pct = 0;
      recv_idle_pct = 0;
   endtask

   // --- result side ---
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      mean_word_type m;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (mean_q.size() == 0) begin
            $error("result with none owed: mean_value %h frame_last %b", rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            m = mean_q.pop_front();
            if (rsp_tdata !== m.mean_value) begin
               $error("mean_value expected %h actual %h", m.mean_value, rsp_tdata);
               errors++;
            end
            if (rsp_tlast !== m.frame_last) begin
               $error("frame_last expected %b actual %b", m.frame_last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   int cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[box_mean_filter_2d_core] ERROR");
         $finish;
      end
   end

   initial begin
      restart_stream();
      frames_done = 0;
      words_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_tiny_frames();
      test_edge_geometry();
      test_pause_until_drained();
      test_random_stream();
      wait_drained();
      if (errors == 0 && mean_q.size() == 0)
         $display("[box_mean_filter_2d_core] OK");
      else
         $display("[box_mean_filter_2d_core] ERROR");
      $finish;
   end
endmodule
